// File: sv/heightmap_bilinear_sample_core_defines.svh
`ifndef HEIGHTMAP_BILINEAR_SAMPLE_CORE_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLE_CORE_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define HBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbs same-cycle check failed");

// next-cycle implication, held off while reset is low
`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbs next-cycle check failed");

`endif

// File: sv/hbs_pkg.sv
`timescale 1ns / 1ps

package hbs_pkg;

  localparam int ADDR_W      = 16;
  localparam int PIX_W       = 8;
  localparam int CRD_W       = 17;
  localparam int DIM_W       = 9;
  localparam int HGT_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CORNER_W    = 10;
  localparam int STORE_DEPTH = 65536;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_LENGTH = 2'd1;

  // input function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CORNER_BL,
    CORNER_BR,
    CORNER_TL,
    CORNER_TR
  } corner_t;

  typedef enum logic [2:0] {
    MAC_TL,
    MAC_TR,
    MAC_BL,
    MAC_BR,
    MAC_BOT,
    MAC_TOP
  } mac_step_t;

  typedef struct packed {
    logic      wr_en;
    logic      capture;
    logic      calc_addr;
    logic      rd_en;
    corner_t   rd_sel;
    logic      cap_en;
    corner_t   cap_sel;
    logic      fix_en;
    logic      mac_en;
    mac_step_t mac_step;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic out_busy;
  } sts_t;

endpackage

// File: sv/hbs_ram.sv
`timescale 1ns / 1ps

module hbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/hbs_ctrl.sv
`timescale 1ns / 1ps
`include "heightmap_bilinear_sample_core_defines.svh"

module hbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_func,
  output logic          in_stall,
  input  hbs_pkg::sts_t sts_i,
  output hbs_pkg::cmd_t cmd_o
);

  import hbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR,
    S_RD_BL,
    S_RD_BR,
    S_RD_TL,
    S_RD_TR,
    S_CAP_TR,
    S_FIX,
    S_MAC_TL,
    S_MAC_TR,
    S_MAC_BL,
    S_MAC_BR,
    S_MAC_BOT,
    S_MAC_TOP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;
  logic   in_acc;

  assign in_acc = in_valid && !in_stall_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_func == FUNC_QUERY) state_nxt = S_ADDR;
      end
      S_ADDR:    state_nxt = sts_i.oor ? S_DONE : S_RD_BL;
      S_RD_BL:   state_nxt = S_RD_BR;
      S_RD_BR:   state_nxt = S_RD_TL;
      S_RD_TL:   state_nxt = S_RD_TR;
      S_RD_TR:   state_nxt = S_CAP_TR;
      S_CAP_TR:  state_nxt = S_FIX;
      S_FIX:     state_nxt = S_MAC_TL;
      S_MAC_TL:  state_nxt = S_MAC_TR;
      S_MAC_TR:  state_nxt = S_MAC_BL;
      S_MAC_BL:  state_nxt = S_MAC_BR;
      S_MAC_BR:  state_nxt = S_MAC_BOT;
      S_MAC_BOT: state_nxt = S_MAC_TOP;
      S_MAC_TOP: state_nxt = S_DONE;
      S_DONE: begin
        if (!sts_i.out_busy) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

  always_comb begin
    cmd_o           = '0;
    cmd_o.rd_sel    = CORNER_BL;
    cmd_o.cap_sel   = CORNER_BL;
    cmd_o.mac_step  = MAC_TL;
    cmd_o.wr_en     = (state_r == S_IDLE) && in_acc && (in_func == FUNC_WRITE);
    cmd_o.capture   = (state_r == S_IDLE) && in_acc && (in_func == FUNC_QUERY);
    case (state_r)
      S_ADDR:    cmd_o.calc_addr = 1'b1;
      S_RD_BL: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = CORNER_BL;
      end
      S_RD_BR: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = CORNER_BR;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = CORNER_BL;
      end
      S_RD_TL: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = CORNER_TL;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = CORNER_BR;
      end
      S_RD_TR: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = CORNER_TR;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = CORNER_TL;
      end
      S_CAP_TR: begin
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = CORNER_TR;
      end
      S_FIX:     cmd_o.fix_en = 1'b1;
      S_MAC_TL: begin
        cmd_o.mac_en   = 1'b1;
        cmd_o.mac_step = MAC_TL;
      end
      S_MAC_TR: begin
        cmd_o.mac_en   = 1'b1;
        cmd_o.mac_step = MAC_TR;
      end
      S_MAC_BL: begin
        cmd_o.mac_en   = 1'b1;
        cmd_o.mac_step = MAC_BL;
      end
      S_MAC_BR: begin
        cmd_o.mac_en   = 1'b1;
        cmd_o.mac_step = MAC_BR;
      end
      S_MAC_BOT: begin
        cmd_o.mac_en   = 1'b1;
        cmd_o.mac_step = MAC_BOT;
      end
      S_MAC_TOP: begin
        cmd_o.mac_en   = 1'b1;
        cmd_o.mac_step = MAC_TOP;
      end
      S_DONE:    cmd_o.load_out = !sts_i.out_busy;
      default: begin
      end
    endcase
  end

  // a result is never loaded over a word that is still held
  `HBS_ASSERT_IMPL(a_load_free, clk, rst_n, cmd_o.load_out, !sts_i.out_busy)
  // a taken query starts with the address step
  `HBS_ASSERT_NEXT(a_query_addr, clk, rst_n, cmd_o.capture, state_r == S_ADDR)
  // once the result slot frees the controller goes back to waiting
  `HBS_ASSERT_NEXT(a_done_idle, clk, rst_n, (state_r == S_DONE) && !sts_i.out_busy, state_r == S_IDLE)

endmodule

// File: sv/hbs_dpath.sv
`timescale 1ns / 1ps

module hbs_dpath #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hbs_pkg::cmd_t                       cmd_i,
  output hbs_pkg::sts_t                       sts_o,
  input  logic                                cfg_wr,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hbs_pkg::DIM_W-1:0]           cfg_data,
  input  logic [hbs_pkg::ADDR_W-1:0]          in_pixel_address,
  input  logic [hbs_pkg::PIX_W-1:0]           in_pixel_value,
  input  logic signed [hbs_pkg::CRD_W-1:0]    in_coord_x,
  input  logic signed [hbs_pkg::CRD_W-1:0]    in_coord_z,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [hbs_pkg::HGT_W-1:0]           out_height,
  output logic                                out_out_of_range
);

  import hbs_pkg::*;

  localparam int TW = FRAC_BITS + 11;       // row sums, scaled by one
  localparam int SW = 2 * FRAC_BITS + 11;   // full sum, scaled by one squared
  localparam int PW = TW + FRAC_BITS + 2;   // raw product
  localparam int HW = SW - 1 - FRAC_BITS;   // positive sum, scaled by one
  localparam logic [FRAC_BITS:0] FIX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration
  logic [DIM_W-1:0] map_width_r, map_length_r;
  logic [DIM_W-1:0] w_eff, l_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= DIM_RESET;
      map_length_r <= DIM_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_width_r  <= cfg_data;
        REG_MAP_LENGTH: map_length_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign w_eff = (32'(map_width_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : map_width_r;
  assign l_eff = (32'(map_length_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : map_length_r;

  // query coordinates
  logic signed [CRD_W-1:0] cx_r, cz_r;

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cx_r <= in_coord_x;
      cz_r <= in_coord_z;
    end
  end

  logic [ADDR_W-1:0]          ix, iz;
  logic [CRD_W-1:0]           ix_inc, iz_inc;
  logic [FRAC_BITS-1:0]       fx, fz;
  logic [FRAC_BITS:0]         one_m_fx, one_m_fz, fsum;
  logic                       oor;
  logic [ADDR_W+DIM_W-1:0]    row_prod;

  assign ix       = cx_r[CRD_W-2:0] >> FRAC_BITS;
  assign iz       = cz_r[CRD_W-2:0] >> FRAC_BITS;
  assign ix_inc   = {1'b0, ix} + CRD_W'(1);
  assign iz_inc   = {1'b0, iz} + CRD_W'(1);
  assign fx       = cx_r[FRAC_BITS-1:0];
  assign fz       = cz_r[FRAC_BITS-1:0];
  assign one_m_fx = FIX_ONE - {1'b0, fx};
  assign one_m_fz = FIX_ONE - {1'b0, fz};
  assign fsum     = {1'b0, fx} + {1'b0, fz};
  assign oor      = cx_r[CRD_W-1] || cz_r[CRD_W-1] ||
                    (ix_inc >= CRD_W'(w_eff)) || (iz_inc >= CRD_W'(l_eff));
  assign row_prod = iz * w_eff;

  logic [ADDR_W-1:0] base_r;
  logic              oor_r;

  always_ff @(posedge clk) begin
    if (cmd_i.calc_addr) begin
      base_r <= row_prod[ADDR_W-1:0] + ix;
      oor_r  <= oor;
    end
  end

  // heightmap store, one write or one read a cycle
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;
  logic [ADDR_W-1:0] w_step;

  assign w_step = ADDR_W'(w_eff);

  always_comb begin
    case (cmd_i.rd_sel)
      CORNER_BL: rd_addr = base_r;
      CORNER_BR: rd_addr = base_r + ADDR_W'(1);
      CORNER_TL: rd_addr = base_r + w_step;
      CORNER_TR: rd_addr = base_r + w_step + ADDR_W'(1);
      default:   rd_addr = base_r;
    endcase
  end

  hbs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd_i.wr_en),
    .waddr (in_pixel_address),
    .wdata (in_pixel_value),
    .re    (cmd_i.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // corners, patched in place for the triangle split
  logic signed [CORNER_W-1:0] bl_r, br_r, tl_r, tr_r;
  logic signed [CORNER_W-1:0] rd_corner;
  logic signed [CORNER_W-1:0] fix_bl, fix_br, fix_tl, fix_tr;

  assign rd_corner = $signed({{(CORNER_W-PIX_W){1'b0}}, rd_data});

  always_comb begin
    fix_bl = bl_r;
    fix_br = br_r;
    fix_tl = tl_r;
    fix_tr = tr_r;
    if (cz_r[FRAC_BITS]) begin
      if (fx <= fz) fix_br = bl_r + tr_r - tl_r;
      else          fix_tl = tr_r + bl_r - br_r;
    end else begin
      if (fsum < FIX_ONE) fix_tr = tl_r + br_r - bl_r;
      else                fix_bl = tl_r + br_r - tr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.cap_en) begin
      case (cmd_i.cap_sel)
        CORNER_BL: bl_r <= rd_corner;
        CORNER_BR: br_r <= rd_corner;
        CORNER_TL: tl_r <= rd_corner;
        CORNER_TR: tr_r <= rd_corner;
        default: begin
        end
      endcase
    end else if (cmd_i.fix_en) begin
      bl_r <= fix_bl;
      br_r <= fix_br;
      tl_r <= fix_tl;
      tr_r <= fix_tr;
    end
  end

  // shared multiply-accumulate
  logic signed [TW-1:0] top_r, bot_r;
  logic signed [SW-1:0] acc_r;
  logic signed [TW-1:0] mac_a;
  logic [FRAC_BITS:0]   mac_b;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] prod_s;

  always_comb begin
    case (cmd_i.mac_step)
      MAC_TL: begin
        mac_a = TW'(tl_r);
        mac_b = one_m_fx;
      end
      MAC_TR: begin
        mac_a = TW'(tr_r);
        mac_b = {1'b0, fx};
      end
      MAC_BL: begin
        mac_a = TW'(bl_r);
        mac_b = one_m_fx;
      end
      MAC_BR: begin
        mac_a = TW'(br_r);
        mac_b = {1'b0, fx};
      end
      MAC_BOT: begin
        mac_a = bot_r;
        mac_b = one_m_fz;
      end
      MAC_TOP: begin
        mac_a = top_r;
        mac_b = {1'b0, fz};
      end
      default: begin
        mac_a = top_r;
        mac_b = {1'b0, fz};
      end
    endcase
  end

  assign prod   = mac_a * $signed({1'b0, mac_b});
  assign prod_s = prod[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd_i.mac_en) begin
      case (cmd_i.mac_step)
        MAC_TL:  acc_r <= prod_s;
        MAC_TR:  top_r <= TW'(acc_r + prod_s);
        MAC_BL:  acc_r <= prod_s;
        MAC_BR:  bot_r <= TW'(acc_r + prod_s);
        MAC_BOT: acc_r <= prod_s;
        MAC_TOP: acc_r <= acc_r + prod_s;
        default: begin
        end
      endcase
    end
  end

  // drop FRAC_BITS fraction bits, clamp to the output range
  logic [HW-1:0]    h_whole;
  logic [HGT_W-1:0] res_height;

  assign h_whole = acc_r[SW-2:FRAC_BITS];

  always_comb begin
    if (acc_r[SW-1])                res_height = '0;
    else if (32'(h_whole) > 32'hFFFF) res_height = {HGT_W{1'b1}};
    else                            res_height = HGT_W'(h_whole);
  end

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [HGT_W-1:0] out_height_r;
  logic             out_oor_r;

  assign out_valid_nxt = cmd_i.load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_height_r <= oor_r ? '0 : res_height;
      out_oor_r    <= oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_height       = out_height_r;
  assign out_out_of_range = out_oor_r;

  assign sts_o.oor      = oor;
  assign sts_o.out_busy = out_valid_r && out_stall;

endmodule

// File: sv/heightmap_bilinear_sample_core.sv
`timescale 1ns / 1ps
// channel   handshake               word
// --------  ----------------------  ---------------------------------------------
// in_       in_valid / in_stall     func, pixel_address, pixel_value, coord_x/z
// out_      out_valid / out_stall   height, out_of_range
// cfg_      cfg_valid / cfg_ready   index (0 map_width, 1 map_length), data
//
// a pixel write does not raise in_stall, so the next word can be taken straight after it
// an in-range query holds the input from when it is taken through the address
//   multiply, four corner reads on the single read port of the heightmap ram,
//   the triangle patch, the row sums and the final sum on the shared multiplier
//   and the load of the output register once a held word has left it
// an out-of-range query goes from the address step straight to that load
// reset is synchronous and active low; the ram is not cleared and settles only
//   as pixels are written; map_width and map_length come up as 256
// the finished word sits in the output register, so a stalled out_ channel only
//   holds the controller once the next query's result is ready

module heightmap_bilinear_sample_core #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [hbs_pkg::ADDR_W-1:0]       in_pixel_address,
  input  logic [hbs_pkg::PIX_W-1:0]        in_pixel_value,
  input  logic signed [hbs_pkg::CRD_W-1:0] in_coord_x,
  input  logic signed [hbs_pkg::CRD_W-1:0] in_coord_z,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hbs_pkg::HGT_W-1:0]        out_height,
  output logic                             out_out_of_range,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hbs_pkg::DIM_W-1:0]        cfg_data
);

  import hbs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  // registers are plain flops, always open to a write
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // sequencing: waits for a word, then steps one query through the datapath
  hbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // heightmap ram, range check, corner fetch, patch and interpolation
  hbs_dpath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_wr           (cfg_wr),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_pixel_address (in_pixel_address),
    .in_pixel_value   (in_pixel_value),
    .in_coord_x       (in_coord_x),
    .in_coord_z       (in_coord_z),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_height       (out_height),
    .out_out_of_range (out_out_of_range)
  );

endmodule
